FILE: sv/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package skf_pkg;

  // action codes carried in the input tuser
  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_INIT   = 2'd1;
  localparam logic [1:0] ACT_RESET  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd1;
  localparam logic [1:0] REG_INITIAL_ERROR = 2'd2;
  localparam logic [1:0] REG_INITIAL_VALUE = 2'd3;

  localparam int EST_W      = 20;
  localparam int GAIN_W     = 17;
  localparam int COV_W      = 32;
  localparam int OUT_TDATA_W = 40;   // estimate + gain, padded to bytes
  localparam int ACC_E_W    = 38;    // signed (m - x) * k
  localparam int ACC_P_W    = 49;    // k * pp
  localparam int GAIN_STEPS = 17;

  localparam logic [COV_W-1:0]  PQ_RESET   = 32'd6554;
  localparam logic [COV_W-1:0]  ONE_Q16    = 32'd65536;

  // sequencer to divider/accumulator unit
  typedef struct packed {
    logic load;   // register denominator, clear accumulators
    logic step;   // one gain bit
    logic first;  // first step: integer bit of the gain, no remainder shift
  } skf_ctrl_t;

  // sequencer to output register
  typedef struct packed {
    logic              load;
    logic [EST_W-1:0]  estimate;
    logic [GAIN_W-1:0] gain;
    logic              initialized;
  } skf_result_t;

endpackage
`default_nettype wire

FILE: sv/skf_div_mac.sv
// Bit-serial gain divider k = pp*2^16/(pp+r), one quotient bit per cycle of ctrl.step,
// MSB first, with the two gain products accumulated alongside. Depends on skf_pkg.
`default_nettype none
module skf_div_mac
  import skf_pkg::*;
(
  input  wire logic                       clk,
  input  wire skf_ctrl_t                  ctrl,
  input  wire logic [COV_W-1:0]           pp,
  input  wire logic [COV_W-1:0]           r_noise,
  input  wire logic signed [EST_W:0]      diff,
  output logic [GAIN_W-1:0]               gain,
  output logic signed [ACC_E_W-1:0]       acc_e,
  output logic [ACC_P_W-1:0]              acc_p
);

  logic [COV_W:0]             den_r;
  logic [COV_W:0]             rem_r;
  logic signed [EST_W:0]      diff_r;
  logic [GAIN_W-1:0]          gain_r;
  logic signed [ACC_E_W-1:0]  acc_e_r;
  logic [ACC_P_W-1:0]         acc_p_r;

  logic [COV_W+1:0]           shifted;
  logic                       qbit;
  logic [COV_W:0]             rem_nxt;
  logic signed [ACC_E_W-1:0]  acc_e_nxt;
  logic [ACC_P_W-1:0]         acc_p_nxt;

  always_comb begin
    shifted = ctrl.first ? {1'b0, rem_r} : {rem_r, 1'b0};
    qbit    = (den_r != '0) && (shifted >= {1'b0, den_r});
    if (qbit) begin
      rem_nxt = (COV_W+1)'(shifted - {1'b0, den_r});
    end else begin
      rem_nxt = shifted[COV_W:0];
    end
    // MSB-first shift-add, so each product sees the gain bit as it appears
    acc_e_nxt = (acc_e_r <<< 1) + (qbit ? ACC_E_W'(diff_r) : '0);
    acc_p_nxt = (acc_p_r << 1) + (qbit ? ACC_P_W'(pp) : '0);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      den_r   <= {1'b0, pp} + {1'b0, r_noise};
      rem_r   <= {1'b0, pp};
      diff_r  <= diff;
      gain_r  <= '0;
      acc_e_r <= '0;
      acc_p_r <= '0;
    end else if (ctrl.step) begin
      rem_r   <= rem_nxt;
      gain_r  <= {gain_r[GAIN_W-2:0], qbit};
      acc_e_r <= acc_e_nxt;
      acc_p_r <= acc_p_nxt;
    end
  end

  assign gain  = gain_r;
  assign acc_e = acc_e_r;
  assign acc_p = acc_p_r;

endmodule
`default_nettype wire

FILE: sv/skf_out_reg.sv
// Output register for result transactions; frees the input side while a result waits.
// Depends on skf_pkg.
`default_nettype none
module skf_out_reg
  import skf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire skf_result_t              res,
  output logic                          free,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [OUT_TDATA_W-1:0]        out_tdata,   // estimate[19:0], gain[36:20], zero pad
  output logic                          out_tuser    // initialized
);

  logic                     valid_r;
  logic [OUT_TDATA_W-1:0]   data_r;
  logic                     user_r;

  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.load && free) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load && free) begin
      data_r <= {(OUT_TDATA_W-EST_W-GAIN_W)'(0), res.gain, res.estimate};
      user_r <= res.initialized;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule
`default_nettype wire

FILE: sv/scalar_kalman_filter_unit.sv
// One-dimensional Kalman filter for ADC samples: sequencer, state and configuration.
// Depends on skf_pkg, skf_div_mac and skf_out_reg.
//
// Items arrive one at a time; the action in in_tuser selects a sample update, an
// init from the configuration registers or a reset. For an update on an initialised
// filter the sequencer loads the divider (S_PREP), runs 17 restoring divider steps
// giving one gain bit each (both gain products built by shift-add in the same steps)
// in S_DIV, writes back the state (S_FIN) and loads the output register (S_WB).
// Init, reset, the unused action and an update before init go from acceptance
// straight to S_WB. The sequencer returns to rest as the result is loaded; a full
// output register holds it in S_WB until the held result is taken. The next item is
// accepted as soon as the sequencer is back at rest, even while the previous result
// is still held. Configuration writes are registered and are meant for idle periods
// only.
`default_nettype none
module scalar_kalman_filter_unit
  import skf_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,  // sample[SAMPLE_BITS-1:0], zero pad
  input  wire logic [1:0]                          in_tuser,  // action[1:0]
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [OUT_TDATA_W-1:0]                   out_tdata, // estimate[19:0], gain[36:20]
  output logic                                     out_tuser, // initialized
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_addr,
  input  wire logic [COV_W-1:0]                    cfg_wdata
);

  localparam int M_W = SAMPLE_BITS + 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [4:0]         cnt_r;
  logic               raw_r;
  logic [EST_W-1:0]   m_r;
  logic [COV_W-1:0]   pp_r;
  logic [EST_W-1:0]   est_r;
  logic [COV_W-1:0]   err_r;
  logic [GAIN_W-1:0]  gain_r;
  logic               init_r;
  logic [COV_W-1:0]   q_r, r_r, ie_r;
  logic [EST_W-1:0]   iv_r;

  logic [M_W-1:0]     m_wide;
  logic [EST_W-1:0]   m_sat;
  logic [COV_W:0]     pq_sum;
  logic [COV_W-1:0]   pp_sat;
  logic               accept;
  logic               out_free;

  skf_ctrl_t               ctrl;
  skf_result_t             res;
  logic [GAIN_W-1:0]       k_val;
  logic signed [ACC_E_W-1:0] acc_e;
  logic [ACC_P_W-1:0]      acc_p;
  logic signed [EST_W:0]   diff;
  logic signed [ACC_E_W-1:0] e_round;
  logic [EST_W-1:0]        est_new;
  logic [49:0]             p_wide;

  // sample as Q12.8, saturated when it would not fit 20 bits
  assign m_wide = {in_tdata[SAMPLE_BITS-1:0], 8'h00};
  generate
    if (M_W > EST_W) begin : g_sat
      assign m_sat = (|m_wide[M_W-1:EST_W]) ? '1 : m_wide[EST_W-1:0];
    end else begin : g_nosat
      assign m_sat = EST_W'(m_wide);
    end
  endgenerate

  assign pq_sum = {1'b0, err_r} + {1'b0, q_r};
  assign pp_sat = pq_sum[COV_W] ? '1 : pq_sum[COV_W-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign diff = $signed({1'b0, m_r}) - $signed({1'b0, est_r});

  always_comb begin
    ctrl.load  = (state_r == S_PREP);
    ctrl.step  = (state_r == S_DIV);
    ctrl.first = (cnt_r == 5'd0);
  end

  skf_div_mac u_div (
    .clk     (clk),
    .ctrl    (ctrl),
    .pp      (pp_r),
    .r_noise (r_r),
    .diff    (diff),
    .gain    (k_val),
    .acc_e   (acc_e),
    .acc_p   (acc_p)
  );

  // x' = x + round((m - x) * k / 2^16); p' = round(pp - pp * k / 2^16)
  assign e_round = acc_e + ACC_E_W'(32768);
  always_comb begin
    est_new = est_r + EST_W'(e_round >>> 16);
    p_wide  = {2'b00, pp_r, 16'h0000} - {1'b0, acc_p} + 50'd32768;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = ((in_tuser == ACT_UPDATE) && init_r) ? S_PREP : S_WB;
        end
      end
      S_PREP: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == 5'(GAIN_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: state_nxt = S_WB;
      S_WB: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      est_r   <= '0;
      err_r   <= ONE_Q16;
      gain_r  <= '0;
      init_r  <= 1'b0;
      q_r     <= PQ_RESET;
      r_r     <= ONE_Q16;
      ie_r    <= ONE_Q16;
      iv_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_PROCESS_NOISE: q_r  <= cfg_wdata;
          REG_MEASURE_NOISE: r_r  <= cfg_wdata;
          REG_INITIAL_ERROR: ie_r <= cfg_wdata;
          REG_INITIAL_VALUE: iv_r <= cfg_wdata[EST_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DIV) begin
        cnt_r <= cnt_r + 5'd1;
      end else begin
        cnt_r <= '0;
      end
      if (accept) begin
        unique case (in_tuser)
          ACT_INIT: begin
            est_r  <= iv_r;
            err_r  <= ie_r;
            gain_r <= '0;
            init_r <= 1'b1;
          end
          ACT_RESET: begin
            est_r  <= '0;
            err_r  <= ONE_Q16;
            gain_r <= '0;
            init_r <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state_r == S_FIN) begin
        est_r  <= est_new;
        err_r  <= p_wide[47:16];
        gain_r <= k_val;
      end
    end
  end

  // payload captured at acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      m_r   <= m_sat;
      pp_r  <= pp_sat;
      raw_r <= (in_tuser == ACT_UPDATE) && !init_r;
    end
  end

  always_comb begin
    res.load        = (state_r == S_WB);
    res.estimate    = raw_r ? m_r : est_r;
    res.gain        = gain_r;
    res.initialized = init_r;
  end

  skf_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

FILE: tb/sv/scalar_kalman_filter_unit_test.sv
// Self-checking testbench for scalar_kalman_filter_unit: random and directed items, random
// stalls on both streams, and a bit-exact model of the filter in the testbench.
// Depends on skf_pkg and the RTL of the block only.
module scalar_kalman_filter_unit_test;
  import skf_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;  // no action assigned to this code
  localparam int         DRAIN_CYCLES = 24;
  localparam int         STALL_LIMIT  = 5000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         SUB_PHASE    = 110;

  typedef struct packed {
    logic [EST_W-1:0]  estimate;
    logic [GAIN_W-1:0] gain;
    logic              initialized;
  } filter_view_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [15:0]            in_tdata   = '0;   // sample[11:0], zero pad
  logic [1:0]             in_tuser   = ACT_UPDATE;  // action[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // estimate[19:0], gain[36:20]
  logic                   out_tuser;  // initialized
  logic                   cfg_we     = 1'b0;
  logic [1:0]             cfg_addr   = REG_PROCESS_NOISE;
  logic [COV_W-1:0]       cfg_wdata  = '0;

  // filter state and registers as the block should hold them
  logic [EST_W-1:0]  est_q;
  logic [COV_W-1:0]  cov_q;
  logic [GAIN_W-1:0] gain_q;
  logic              init_q;
  logic [COV_W-1:0]  q_noise, r_noise, err_init;
  logic [EST_W-1:0]  val_init;

  filter_view_t pending_results[$];
  int           err_count     = 0;
  int           send_idle_pct = 26;
  int           recv_idle_pct = 70;
  int           hold_len      = 0;
  int           quiet_cycles  = 0;

  scalar_kalman_filter_unit #(.SAMPLE_BITS(12)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // One filter step: updates the state and returns what the block should show.
  function automatic filter_view_t kalman_step(logic [1:0] act, logic [11:0] smp);
    logic [63:0]  pp, den, k, x, p, m;
    logic         pass_through;
    filter_view_t res;
    m = {44'b0, smp, 8'h00};
    pass_through = 1'b0;
    case (act)
      ACT_UPDATE: begin
        if (init_q) begin
          pp = {32'b0, cov_q} + {32'b0, q_noise};
          if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
          den = pp + {32'b0, r_noise};
          k = (den == 0) ? 64'd0 : (pp << 16) / den;
          if (k > 64'd65536) k = 64'd65536;
          x = ({44'b0, est_q} * (64'd65536 - k) + m * k + 64'd32768) >> 16;
          p = ((64'd65536 - k) * pp + 64'd32768) >> 16;
          if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
          est_q  = x[EST_W-1:0];
          cov_q  = p[COV_W-1:0];
          gain_q = k[GAIN_W-1:0];
        end else begin
          pass_through = 1'b1;
        end
      end
      ACT_INIT: begin
        est_q  = val_init;
        cov_q  = err_init;
        gain_q = '0;
        init_q = 1'b1;
      end
      ACT_RESET: begin
        est_q  = '0;
        cov_q  = ONE_Q16;
        gain_q = '0;
        init_q = 1'b0;
      end
      default: ;
    endcase
    res.estimate    = pass_through ? m[EST_W-1:0] : est_q;
    res.gain        = gain_q;
    res.initialized = init_q;
    return res;
  endfunction

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    filter_view_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, actual %h/%h", $time,
                 out_tdata, out_tuser);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[19:0] !== want.estimate) begin
          $display("%0t: estimate mismatch, expected %h, actual %h", $time,
                   want.estimate, out_tdata[19:0]);
          err_count++;
        end
        if (out_tdata[36:20] !== want.gain) begin
          $display("%0t: gain mismatch, expected %h, actual %h", $time,
                   want.gain, out_tdata[36:20]);
          err_count++;
        end
        if (out_tuser !== want.initialized) begin
          $display("%0t: initialized mismatch, expected %b, actual %b", $time,
                   want.initialized, out_tuser);
          err_count++;
        end
      end
    end
  end

  // watchdog: any transaction or register write counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [11:0] smp);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'b0, smp};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    pending_results.push_back(kalman_step(act, smp));
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_config(input logic [31:0] q, input logic [31:0] r,
                              input logic [31:0] e, input logic [19:0] v);
    logic [1:0]  idx [4] = '{REG_PROCESS_NOISE, REG_MEASURE_NOISE,
                             REG_INITIAL_ERROR, REG_INITIAL_VALUE};
    logic [31:0] vals [4];
    vals = '{q, r, e, {12'b0, v}};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    q_noise  = q;
    r_noise  = r;
    err_init = e;
    val_init = v;
  endtask

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      default: return $urandom_range(32'h0004_0000);
    endcase
  endfunction

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(9))
      0:       return 12'd0;
      1:       return 12'hFFF;
      default: return $urandom_range(4095);
    endcase
  endfunction

  function automatic logic [1:0] pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 80) return ACT_UPDATE;
    else if (r < 88) return ACT_INIT;
    else if (r < 94) return ACT_RESET;
    else return ACT_UNUSED;
  endfunction

  // register reset values, pass-through before init, every action code
  task automatic test_reset_defaults();
    send_item(ACT_UPDATE, 12'h000);
    send_item(ACT_UPDATE, 12'hFFF);
    send_item(ACT_UNUSED, 12'h123);
    send_item(ACT_RESET, 12'hFFF);
    send_item(ACT_INIT, 12'h000);
    send_item(ACT_UPDATE, 12'hFFF);
    send_item(ACT_UPDATE, 12'hAAA);
    send_item(ACT_UPDATE, 12'h555);
    send_item(ACT_UPDATE, 12'h000);
    send_item(ACT_UNUSED, 12'hFFF);
    send_item(ACT_RESET, 12'h000);
    send_item(ACT_UPDATE, 12'h800);
    wait_results_drained();
  endtask

  // p + q + r == 0: gain forced to zero, estimate must hold
  task automatic test_zero_denominator();
    write_config(32'd0, 32'd0, 32'd0, 20'hFFFFF);
    send_item(ACT_INIT, 12'h000);
    send_item(ACT_UPDATE, 12'h000);
    send_item(ACT_UPDATE, 12'hFFF);
    wait_results_drained();
  endtask

  // p + q saturating, unity gain and all-ones noise
  task automatic test_saturation();
    write_config(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 20'd0);
    send_item(ACT_INIT, 12'h000);
    send_item(ACT_UPDATE, 12'hFFF);
    send_item(ACT_UPDATE, 12'h000);
    wait_results_drained();
    write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF);
    send_item(ACT_INIT, 12'h000);
    send_item(ACT_UPDATE, 12'h000);
    send_item(ACT_UPDATE, 12'hFFF);
    wait_results_drained();
  endtask

  // random settings per sub-phase, each starting from an init
  task automatic test_random_filtering(input int n_items, input int s_pct, input int r_pct);
    int left;
    int chunk;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    left = n_items;
    while (left > 0) begin
      chunk = (left < SUB_PHASE) ? left : SUB_PHASE;
      write_config(pick_q16(), pick_q16(), pick_q16(),
                   ($urandom_range(3) == 0) ? 20'hFFFFF : 20'($urandom_range(20'hFFFFF)));
      send_item(ACT_INIT, pick_sample());
      for (int i = 1; i < chunk; i++) send_item(pick_action(), pick_sample());
      wait_results_drained();
      left -= chunk;
    end
  endtask

  // output held off for a long stretch while items keep coming
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_config(32'd6554, 32'd65536, 32'd65536, 20'h12345);
    hold_len <= HOLD_CYCLES;
    send_item(ACT_INIT, 12'h000);
    for (int i = 0; i < 24; i++) send_item(ACT_UPDATE, pick_sample());
    wait_results_drained();
  endtask

  initial begin
    q_noise  = PQ_RESET;
    r_noise  = ONE_Q16;
    err_init = ONE_Q16;
    val_init = '0;
    est_q    = '0;
    cov_q    = ONE_Q16;
    gain_q   = '0;
    init_q   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_denominator();
    test_saturation();
    test_random_filtering(550, 26, 70);
    test_random_filtering(550, 70, 26);
    test_output_backpressure();
    test_random_filtering(550, 0, 0);

    if (err_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/skf_pkg.sv
sv/skf_div_mac.sv
sv/skf_out_reg.sv
sv/scalar_kalman_filter_unit.sv
tb/sv/scalar_kalman_filter_unit_test.sv
